### rtl/spi_pwm_pkg.sv
// Shared constants for the SPI PWM command register slave.
// Command codes, word widths and stream packing widths. No dependencies.
package spi_pwm_pkg;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CMP_W     = 32;
    localparam int unsigned EN_W      = 8;
    localparam int unsigned CMD_W     = 4;
    localparam int unsigned OUT_BITS  = WORD_W + CMP_W + CMP_W + WORD_W + 2;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes carried by a first-slot word
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE       = 4'd0,
        CMD_A_HI       = 4'd1,
        CMD_A_LO       = 4'd2,
        CMD_B_HI       = 4'd3,
        CMD_B_LO       = 4'd4,
        CMD_LED_WR     = 4'd5,
        CMD_A_HI_RD    = 4'd6,
        CMD_A_LO_RD    = 4'd7,
        CMD_B_HI_RD    = 4'd8,
        CMD_B_LO_RD    = 4'd9,
        CMD_LED_RD     = 4'd10,
        CMD_EN_WR      = 4'd11,
        CMD_EN_RD      = 4'd12
    } cmd_t;

    localparam logic [WORD_W-1:0] CMD_MAX_WORD = WORD_W'(CMD_EN_RD);

endpackage

### rtl/spi_pwm_command_register_slave.sv
// SPI PWM command register slave: top level.
// Depends on spi_pwm_pkg for command codes and widths.
//
// Usage:
//   s_axis_*  carries one received SPI word per stream word. Words alternate
//             between a command slot and a data slot, starting with a command
//             slot after reset. A command word of 1..12 selects the command;
//             other values leave the previous command in place.
//   m_axis_*  returns one word per input word: the reply to load for the
//             next SPI transfer, plus the committed PWM compares, LED compare
//             and channel enables as they stand after that input word.
// Pipeline: an input word is registered, then decoded against the register
//   file; its result is registered and presented on m_axis.
// Throughput: one word per cycle while m_axis_tready stays high. The input register and the result
//   register each take a new word whenever the stage ahead frees up.
// Reset: all compares, staging registers, enables, the held word, the
//   command and the slot/pair tracking clear to zero; both stages empty.
// Stall: while m_axis_tready is low the result holds, the input stage
//   fills, and s_axis_tready drops once both stages hold a word.
module spi_pwm_command_register_slave (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] spi_word
    input  logic [spi_pwm_pkg::WORD_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] reply_word, [47:16] compare_a, [79:48] compare_b,
    // [95:80] led_compare, [96] enable_a, [97] enable_b, [103:98] zero
    output logic [spi_pwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import spi_pwm_pkg::*;

    // Pipeline control
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] reply_reg;
    logic              out_load;
    logic              in_load;

    // Register file
    logic              slot_phase_reg, slot_phase_next;
    logic              pair_parity_reg, pair_parity_next;
    cmd_t              cmd_reg, cmd_next;
    logic [WORD_W-1:0] held_reg, held_next;
    logic [CMP_W-1:0]  staging_a_reg, staging_a_next;
    logic [CMP_W-1:0]  committed_a_reg, committed_a_next;
    logic [CMP_W-1:0]  staging_b_reg, staging_b_next;
    logic [CMP_W-1:0]  committed_b_reg, committed_b_next;
    logic [WORD_W-1:0] led_reg, led_next;
    logic [EN_W-1:0]   enable_reg, enable_next;
    logic [WORD_W-1:0] reply_next;
    logic              go;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_word_reg <= s_axis_tdata;
        end
    end

    // Slot decode and register file update
    always_comb
    begin
        slot_phase_next  = slot_phase_reg;
        pair_parity_next = pair_parity_reg;
        cmd_next         = cmd_reg;
        held_next        = held_reg;
        staging_a_next   = staging_a_reg;
        committed_a_next = committed_a_reg;
        staging_b_next   = staging_b_reg;
        committed_b_next = committed_b_reg;
        led_next         = led_reg;
        enable_next      = enable_reg;
        reply_next       = in_word_reg;
        go               = pair_parity_reg;

        if (!slot_phase_reg)
        begin
            // command slot: latch word, take it as command if in range
            held_next       = in_word_reg;
            slot_phase_next = 1'b1;
            if (in_word_reg != '0 && in_word_reg <= CMD_MAX_WORD)
            begin
                cmd_next = cmd_t'(in_word_reg[CMD_W-1:0]);
            end
        end
        else
        begin
            // data slot: act on held word, compare and LED writes gated by pair parity
            slot_phase_next  = 1'b0;
            pair_parity_next = !pair_parity_reg;
            unique case (cmd_reg)
                CMD_A_HI:
                begin
                    if (go)
                    begin
                        staging_a_next = {held_reg, {WORD_W{1'b0}}};
                    end
                end
                CMD_A_LO:
                begin
                    if (go)
                    begin
                        staging_a_next   = staging_a_reg | {{WORD_W{1'b0}}, held_reg};
                        committed_a_next = staging_a_reg | {{WORD_W{1'b0}}, held_reg};
                    end
                end
                CMD_B_HI:
                begin
                    if (go)
                    begin
                        staging_b_next = {held_reg, {WORD_W{1'b0}}};
                    end
                end
                CMD_B_LO:
                begin
                    if (go)
                    begin
                        staging_b_next   = staging_b_reg | {{WORD_W{1'b0}}, held_reg};
                        committed_b_next = staging_b_reg | {{WORD_W{1'b0}}, held_reg};
                    end
                end
                CMD_LED_WR:
                begin
                    if (go)
                    begin
                        led_next = held_reg;
                    end
                end
                CMD_A_HI_RD: reply_next = committed_a_reg[CMP_W-1:WORD_W];
                CMD_A_LO_RD: reply_next = committed_a_reg[WORD_W-1:0];
                CMD_B_HI_RD: reply_next = committed_b_reg[CMP_W-1:WORD_W];
                CMD_B_LO_RD: reply_next = committed_b_reg[WORD_W-1:0];
                CMD_LED_RD:  reply_next = led_reg;
                CMD_EN_WR:   enable_next = held_reg[EN_W-1:0];
                CMD_EN_RD:   reply_next = {{(WORD_W-EN_W){1'b0}}, enable_reg};
                default:     reply_next = held_reg;    // no command yet
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_phase_reg  <= 1'b0;
            pair_parity_reg <= 1'b0;
            cmd_reg         <= CMD_NONE;
            held_reg        <= '0;
            staging_a_reg   <= '0;
            committed_a_reg <= '0;
            staging_b_reg   <= '0;
            committed_b_reg <= '0;
            led_reg         <= '0;
            enable_reg      <= '0;
        end
        else if (out_load)
        begin
            slot_phase_reg  <= slot_phase_next;
            pair_parity_reg <= pair_parity_next;
            cmd_reg         <= cmd_next;
            held_reg        <= held_next;
            staging_a_reg   <= staging_a_next;
            committed_a_reg <= committed_a_next;
            staging_b_reg   <= staging_b_next;
            committed_b_reg <= committed_b_next;
            led_reg         <= led_next;
            enable_reg      <= enable_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            reply_reg <= reply_next;
        end
    end

    // Compares and enables are read straight from the register file, which
    // only moves when a new result is loaded.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                            enable_reg[1], enable_reg[0], led_reg,
                            committed_b_reg, committed_a_reg, reply_reg};

endmodule

### tb/tb_spi_pwm_command_register_slave.sv
// Testbench for the SPI PWM command register slave: streams SPI words in,
// predicts each reply and the register outputs, and checks every result word.
// Depends on spi_pwm_pkg and the RTL top level spi_pwm_command_register_slave.
`timescale 1ns / 100ps

module tb_spi_pwm_command_register_slave;
    import spi_pwm_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned SHOW_LIMIT   = 10;
    localparam int unsigned PHASE_WORDS  = 150;
    localparam int unsigned TAIL_CYCLES  = 10;

    // Result word fields, packed with reply_word in the low bits
    typedef struct packed {
        logic              en_b;
        logic              en_a;
        logic [WORD_W-1:0] led;
        logic [CMP_W-1:0]  cmp_b;
        logic [CMP_W-1:0]  cmp_a;
        logic [WORD_W-1:0] reply;
    } reg_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [WORD_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Stimulus and scoreboard storage
    logic [WORD_W-1:0] pending_words[$];
    reg_result_t       expected_replies[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned replies_checked = 0;
    int unsigned gated_writes = 0;
    int unsigned input_stalls = 0;
    int unsigned cmd_hits[CMD_NONE:CMD_EN_RD];

    // Register file as the predictor sees it
    logic              second_slot_q = 1'b0;
    logic              pair_odd = 1'b0;
    cmd_t              cmd_q = CMD_NONE;
    logic [WORD_W-1:0] held_q = '0;
    logic [CMP_W-1:0]  stage_a = '0;
    logic [CMP_W-1:0]  commit_a = '0;
    logic [CMP_W-1:0]  stage_b = '0;
    logic [CMP_W-1:0]  commit_b = '0;
    logic [WORD_W-1:0] led_q = '0;
    logic [EN_W-1:0]   en_q = '0;

    reg_result_t got_result;
    reg_result_t want_result;

    spi_pwm_command_register_slave DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one accepted SPI word to the register file and queue its reply
    task automatic predict_reply(input logic [WORD_W-1:0] w);
        reg_result_t r;
        logic [WORD_W-1:0] h;
        logic go;
        h = held_q;
        go = pair_odd;
        if (!second_slot_q)
        begin
            // command slot: valid codes latch, anything else keeps the old one
            held_q = w;
            if (w != '0 && w <= CMD_MAX_WORD)
                cmd_q = cmd_t'(w[CMD_W-1:0]);
            r.reply = w;
            second_slot_q = 1'b1;
        end
        else
        begin
            r.reply = h;
            cmd_hits[cmd_q]++;
            if (go && cmd_q inside {CMD_A_HI, CMD_A_LO, CMD_B_HI, CMD_B_LO, CMD_LED_WR})
                gated_writes++;
            case (cmd_q)
                CMD_A_HI:
                begin
                    if (go) stage_a = {h, 16'h0000};
                    r.reply = w;
                end
                CMD_A_LO:
                begin
                    if (go)
                    begin
                        stage_a = stage_a | {16'h0000, h};
                        commit_a = stage_a;
                    end
                    r.reply = w;
                end
                CMD_B_HI:
                begin
                    if (go) stage_b = {h, 16'h0000};
                    r.reply = w;
                end
                CMD_B_LO:
                begin
                    if (go)
                    begin
                        stage_b = stage_b | {16'h0000, h};
                        commit_b = stage_b;
                    end
                    r.reply = w;
                end
                CMD_LED_WR:
                begin
                    if (go) led_q = h;
                    r.reply = w;
                end
                CMD_A_HI_RD: r.reply = commit_a[31:16];
                CMD_A_LO_RD: r.reply = commit_a[15:0];
                CMD_B_HI_RD: r.reply = commit_b[31:16];
                CMD_B_LO_RD: r.reply = commit_b[15:0];
                CMD_LED_RD:  r.reply = led_q;
                CMD_EN_WR:
                begin
                    // enables are not gated by pair parity
                    en_q = h[EN_W-1:0];
                    r.reply = w;
                end
                CMD_EN_RD:   r.reply = {8'h00, en_q};
                default: ;   // no command yet: echo the held word
            endcase
            pair_odd = ~pair_odd;
            second_slot_q = 1'b0;
        end
        r.cmp_a = commit_a;
        r.cmp_b = commit_b;
        r.led   = led_q;
        r.en_a  = en_q[0];
        r.en_b  = en_q[1];
        expected_replies.push_back(r);
    endtask

    // Driver: offers the next pending word, predicting each one accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                predict_reply(s_axis_tdata);
                words_sent++;
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_words.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        else
            input_stalls++;
    end

    // Receiver: random backpressure plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result = reg_result_t'(m_axis_tdata[OUT_BITS-1:0]);
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: unexpected result word %h", $realtime, m_axis_tdata);
            end
            else
            begin
                want_result = expected_replies.pop_front();
                replies_checked++;
                if (got_result !== want_result)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"%0t: mismatch reply %h/%h cmp_a %h/%h cmp_b %h/%h ",
                                  "led %h/%h en_a %b/%b en_b %b/%b (expected/actual)"},
                                 $realtime, want_result.reply, got_result.reply,
                                 want_result.cmp_a, got_result.cmp_a,
                                 want_result.cmp_b, got_result.cmp_b,
                                 want_result.led, got_result.led,
                                 want_result.en_a, got_result.en_a,
                                 want_result.en_b, got_result.en_b);
                end
            end
        end
    end

    // Watchdog: no word moving while work is outstanding
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (pending_words.size() == 0 && !s_axis_tvalid &&
                 expected_replies.size() == 0))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Wait until every queued word has gone through and every reply came back
    task automatic wait_drained();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(negedge clk);
    endtask

    // Mostly command/data pairs, some bad command words, some stray words
    task automatic queue_random_words(input int unsigned n);
        int unsigned added;
        int unsigned roll;
        added = 0;
        while (added < n)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                pending_words.push_back(WORD_W'($urandom_range(CMD_A_HI, CMD_EN_RD)));
                pending_words.push_back(WORD_W'($urandom));
                added += 2;
            end
            else if (roll < 92)
            begin
                if ($urandom_range(1))
                    pending_words.push_back('0);
                else
                    pending_words.push_back(WORD_W'($urandom_range(CMD_EN_RD + 1, 16'hFFFF)));
                pending_words.push_back(WORD_W'($urandom));
                added += 2;
            end
            else
            begin
                pending_words.push_back(WORD_W'($urandom));
                added += 1;
            end
        end
    endtask

    // Stimulus sequence
    initial
    begin
        foreach (cmd_hits[k])
            cmd_hits[k] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no command yet, every command once, then a bad command word
        send_idle_pct = 11;
        recv_idle_pct = 64;
        pending_words.push_back(16'h0000);
        pending_words.push_back(16'hFFFF);
        for (int c = CMD_A_HI; c <= CMD_EN_RD; c++)
        begin
            pending_words.push_back(WORD_W'(c));
            pending_words.push_back((c % 2) ? 16'hFFFF : 16'h0000);
        end
        pending_words.push_back(16'hFFFF);
        pending_words.push_back(16'h1234);
        wait_drained();

        queue_random_words(PHASE_WORDS);
        wait_drained();

        send_idle_pct = 64;
        recv_idle_pct = 11;
        queue_random_words(PHASE_WORDS);
        wait_drained();

        // no idling; hold the output off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_words(40);
        hold_requests++;
        queue_random_words(PHASE_WORDS - 40);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run: %0d SPI words sent, %0d result words checked, %0d gated writes taken,",
                 words_sent, replies_checked, gated_writes);
        $display("     %0d input stall cycles; data-slot commands: none %0d, enable read %0d",
                 input_stalls, cmd_hits[CMD_NONE], cmd_hits[CMD_EN_RD]);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
